// File: hdl/atad_pkg.sv
// ----------------------------------------------------------------------------
// Tilt angle detector package
// Shared register layout, configuration struct, fixed-point constants and
// the CORDIC arctangent step table.
// ----------------------------------------------------------------------------
`default_nettype none

package atad_pkg;

  localparam int ANGLE_MAX  = 23040;
  localparam int ANG_FRAC   = 16;
  localparam int PRE_SHIFT  = 30;
  localparam int MAX_STEPS  = 24;
  localparam int ZW         = 34;
  localparam int TI_W       = $clog2(MAX_STEPS);

  // register indexes
  localparam logic [2:0] REG_ABOUT_AXIS  = 3'd0;
  localparam logic [2:0] REG_FIRST_OFFS  = 3'd1;
  localparam logic [2:0] REG_SECOND_OFFS = 3'd2;
  localparam logic [2:0] REG_FIRST_LIM   = 3'd3;
  localparam logic [2:0] REG_SECOND_LIM  = 3'd4;
  localparam logic [2:0] REG_THRESHOLD   = 3'd5;

  // rotation axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [1:0]         about_axis;
    logic signed [15:0] first_axis_offset;
    logic signed [15:0] second_axis_offset;
    logic [15:0]        first_axis_limit;
    logic [15:0]        second_axis_limit;
    logic signed [15:0] rotation_threshold;
  } cfg_t;

  typedef logic [31:0] atan_tbl_t [MAX_STEPS];

  // restoring division, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q32 by the alternating series, truncated terms
  function automatic logic [63:0] atan_inv_q32(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] n2;
    logic [63:0] acc;
    logic [63:0] term;
    p   = udiv(64'd1 << 32, n);
    n2  = n * n;
    acc = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 0) begin
        term = udiv(p, 64'(2 * k + 1));
        if ((k % 2) == 0) acc = acc + term;
        else              acc = acc - term;
        p = udiv(p, n2);
      end
    end
    return acc;
  endfunction

  // atan(2^-i) in degrees * 2^23
  function automatic atan_tbl_t build_atan();
    atan_tbl_t   t;
    logic [63:0] quarter;
    logic [63:0] a;
    quarter = atan_inv_q32(64'd2) + atan_inv_q32(64'd3);
    t[0] = 32'd45 << 23;
    for (int i = 1; i < MAX_STEPS; i++) begin
      a    = atan_inv_q32(64'd1 << i);
      t[i] = 32'(udiv(a * 64'd45 * (64'd1 << 23), quarter));
    end
    return t;
  endfunction

  localparam atan_tbl_t ATAN_TBL = build_atan();

endpackage

`default_nettype wire

// File: hdl/atad_ifs.sv
// ----------------------------------------------------------------------------
// Tilt angle detector channels
// Sample and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface atad_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic               gyro_enabled;
  logic signed [15:0] gyro_angle_x;
  logic signed [15:0] gyro_angle_y;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_enabled,
                  gyro_angle_x, gyro_angle_y, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, gyro_enabled,
                  gyro_angle_x, gyro_angle_y, output ready);
endinterface

interface atad_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tilt_angle;
  logic               angle_updated;
  logic               rot_first;

  modport source (output valid, tilt_angle, angle_updated, rot_first,
                  input ready);
  modport sink   (input valid, tilt_angle, angle_updated, rot_first,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/accel_tilt_angle_detector_unit.sv
// ----------------------------------------------------------------------------
// Accelerometer tilt angle detector
// Windowed axis means, CORDIC atan2 tilt angle and rotation flag, APB config.
// ----------------------------------------------------------------------------
// The window stage passes each sample through its idle, read and calc states;
//   the angle stage answers directly (held angle or a plain quadrant case) or
//   runs the CORDIC iteration and a final state. Neither stage takes a new
//   sample before it is through with the last; a two-entry queue lies between.
// Reset (synchronous, rst_n low): registers to defaults, window unprimed,
//   held angle 0; window memories need no clearing.
`default_nettype none

module accel_tilt_angle_detector_unit #(
  parameter int WINDOW_LEN   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  atad_in_if.sink     in_ch,
  atad_out_if.source  out_ch,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import atad_pkg::*;

  localparam int DW = 17 + $clog2(WINDOW_LEN);
  localparam int QW = 2 * DW + 18;

  cfg_t          cfg_r;
  logic [2:0]    ridx;
  logic          wr_en;
  logic          fq_valid, fq_ready, bq_valid, bq_ready;
  logic [QW-1:0] fq_data, bq_data;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.about_axis         <= AXIS_X;
      cfg_r.first_axis_offset  <= '0;
      cfg_r.second_axis_offset <= '0;
      cfg_r.first_axis_limit   <= 16'hFFFF;
      cfg_r.second_axis_limit  <= 16'hFFFF;
      cfg_r.rotation_threshold <= '0;
    end else if (wr_en) begin
      case (ridx)
        REG_ABOUT_AXIS:  cfg_r.about_axis         <= pwdata[1:0];
        REG_FIRST_OFFS:  cfg_r.first_axis_offset  <= pwdata[15:0];
        REG_SECOND_OFFS: cfg_r.second_axis_offset <= pwdata[15:0];
        REG_FIRST_LIM:   cfg_r.first_axis_limit   <= pwdata[15:0];
        REG_SECOND_LIM:  cfg_r.second_axis_limit  <= pwdata[15:0];
        REG_THRESHOLD:   cfg_r.rotation_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ABOUT_AXIS:  prdata = {30'd0, cfg_r.about_axis};
      REG_FIRST_OFFS:  prdata = 32'(cfg_r.first_axis_offset);
      REG_SECOND_OFFS: prdata = 32'(cfg_r.second_axis_offset);
      REG_FIRST_LIM:   prdata = {16'd0, cfg_r.first_axis_limit};
      REG_SECOND_LIM:  prdata = {16'd0, cfg_r.second_axis_limit};
      REG_THRESHOLD:   prdata = 32'(cfg_r.rotation_threshold);
      default:         prdata = '0;
    endcase
  end

  atad_front #(.WINDOW_LEN(WINDOW_LEN)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_data  (fq_data)
  );

  atad_queue #(.QW(QW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_data)
  );

  atad_back #(.CORDIC_STEPS(CORDIC_STEPS), .DW(DW)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (bq_valid),
    .q_ready (bq_ready),
    .q_data  (bq_data),
    .cfg     (cfg_r),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// File: hdl/atad_front.sv
// ----------------------------------------------------------------------------
// Tilt angle detector front end
// Picks the two axes, runs both sliding-window sums and the limit test.
// ----------------------------------------------------------------------------
`default_nettype none

module atad_front #(
  parameter int WINDOW_LEN = 16,
  localparam int SUM_W = 16 + $clog2(WINDOW_LEN),
  localparam int DW    = SUM_W + 1,
  localparam int QW    = 2 * DW + 18
) (
  input  wire              clk,
  input  wire              rst_n,
  atad_in_if.sink          in_ch,
  input  atad_pkg::cfg_t   cfg,
  output logic             q_valid,
  input  wire              q_ready,
  output logic [QW-1:0]    q_data
);
  import atad_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int EW_W  = $clog2(WINDOW_LEN + 1);
  localparam logic signed [SUM_W-1:0] N_S = SUM_W'(WINDOW_LEN);
  localparam logic signed [DW-1:0]    N_D = DW'(WINDOW_LEN);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_CALC = 3'b100
  } fst_t;

  fst_t st_r, st_nxt;

  logic signed [15:0]      a1_r, a2_r, gsel_r, pf_r, ps_r, rd1_r, rd2_r;
  logic                    gon_r, primed_r;
  logic [IDX_W-1:0]        idx_r;
  logic [EW_W-1:0]         ew_r;
  logic signed [SUM_W-1:0] s1_r, s2_r;
  logic signed [15:0]      mem1 [WINDOW_LEN];
  logic signed [15:0]      mem2 [WINDOW_LEN];

  logic signed [15:0]      a1, a2, gsel, old1, old2;
  logic signed [SUM_W-1:0] a1x, a2x, o1x, o2x, ns1, ns2;
  logic signed [DW-1:0]    d1, d2, off1, off2;
  logic [DW-1:0]           m1, m2, lim1, lim2;
  logic                    upd, accept, commit;

  always_comb begin
    unique case (cfg.about_axis)
      AXIS_Y: begin
        a1 = in_ch.accel_x; a2 = in_ch.accel_z; gsel = in_ch.gyro_angle_y;
      end
      AXIS_Z: begin
        a1 = in_ch.accel_x; a2 = in_ch.accel_y; gsel = in_ch.gyro_angle_y;
      end
      default: begin
        a1 = in_ch.accel_y; a2 = in_ch.accel_z; gsel = in_ch.gyro_angle_x;
      end
    endcase
  end

  assign in_ch.ready = (st_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // entries beyond the fill count stand for the priming sample
  assign old1 = (EW_W'(idx_r) < ew_r) ? rd1_r : pf_r;
  assign old2 = (EW_W'(idx_r) < ew_r) ? rd2_r : ps_r;
  assign a1x  = SUM_W'(a1_r);
  assign a2x  = SUM_W'(a2_r);
  assign o1x  = SUM_W'(old1);
  assign o2x  = SUM_W'(old2);
  assign ns1  = s1_r + a1x - o1x;
  assign ns2  = s2_r + a2x - o2x;
  assign off1 = DW'(cfg.first_axis_offset);
  assign off2 = DW'(cfg.second_axis_offset);
  assign d1   = DW'(ns1) - off1 * N_D;
  assign d2   = DW'(ns2) - off2 * N_D;
  assign m1   = d1[DW-1] ? DW'(-d1) : DW'(d1);
  assign m2   = d2[DW-1] ? DW'(-d2) : DW'(d2);
  assign lim1 = DW'(cfg.first_axis_limit) * DW'(WINDOW_LEN);
  assign lim2 = DW'(cfg.second_axis_limit) * DW'(WINDOW_LEN);
  assign upd  = (m1 <= lim1) && (m2 <= lim2);

  assign q_valid = (st_r == F_CALC);
  assign q_data  = {d1, d2, upd, gon_r, gsel_r};
  assign commit  = q_valid && q_ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE:  if (accept) st_nxt = F_READ;
      F_READ:  st_nxt = F_CALC;
      F_CALC:  if (commit) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= F_IDLE;
      primed_r <= 1'b0;
      idx_r    <= '0;
      ew_r     <= '0;
      s1_r     <= '0;
      s2_r     <= '0;
      pf_r     <= '0;
      ps_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if (accept && !primed_r) begin
        primed_r <= 1'b1;
        pf_r     <= a1;
        ps_r     <= a2;
        idx_r    <= '0;
        ew_r     <= '0;
        s1_r     <= SUM_W'(a1) * N_S;
        s2_r     <= SUM_W'(a2) * N_S;
      end
      if (commit) begin
        s1_r  <= ns1;
        s2_r  <= ns2;
        idx_r <= (idx_r == IDX_W'(WINDOW_LEN - 1)) ? '0 : idx_r + 1'b1;
        if (ew_r != EW_W'(WINDOW_LEN)) ew_r <= ew_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a1_r   <= a1;
      a2_r   <= a2;
      gon_r  <= in_ch.gyro_enabled;
      gsel_r <= gsel;
    end
  end

  // window memories
  always_ff @(posedge clk) begin
    rd1_r <= mem1[idx_r];
    rd2_r <= mem2[idx_r];
    if (commit) begin
      mem1[idx_r] <= a1_r;
      mem2[idx_r] <= a2_r;
    end
  end

endmodule

`default_nettype wire

// File: hdl/atad_queue.sv
// ----------------------------------------------------------------------------
// Tilt angle detector queue
// Two-entry queue between the window stage and the angle stage.
// ----------------------------------------------------------------------------
`default_nettype none

module atad_queue #(
  parameter int QW = 54
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           wr_valid,
  output logic          wr_ready,
  input  wire [QW-1:0]  wr_data,
  output logic          rd_valid,
  input  wire           rd_ready,
  output logic [QW-1:0] rd_data
);
  logic [QW-1:0] buf_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = buf_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= wr_data;
  end

endmodule

`default_nettype wire

// File: hdl/atad_back.sv
// ----------------------------------------------------------------------------
// Tilt angle detector back end
// Iterative CORDIC atan2, angle hold and rotation flag.
// ----------------------------------------------------------------------------
`default_nettype none

module atad_back #(
  parameter int CORDIC_STEPS = 16,
  parameter int DW = 21,
  localparam int QW = 2 * DW + 18
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             q_valid,
  output logic            q_ready,
  input  wire [QW-1:0]    q_data,
  input  atad_pkg::cfg_t  cfg,
  atad_out_if.source      out_ch
);
  import atad_pkg::*;

  localparam int CW    = DW + PRE_SHIFT + 2;
  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 128) <<< ANG_FRAC;
  localparam logic signed [ZW-1:0] ZMAX  = ZW'(ANGLE_MAX);
  localparam logic signed [ZW-1:0] ZHALF = ZW'(1) <<< (ANG_FRAC - 1);
  localparam logic signed [15:0]   A_MAX = 16'(ANGLE_MAX);
  localparam logic signed [15:0]   A_90  = 16'(ANGLE_MAX / 2);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_ITER = 3'b010,
    B_FIN  = 3'b100
  } bst_t;

  bst_t st_r;

  logic signed [DW-1:0] qd1, qd2;
  logic                 qupd, qgon;
  logic signed [15:0]   qgsel;

  logic signed [CW-1:0] cx_r, cy_r, x0, y0, sx, sy;
  logic signed [ZW-1:0] z_r, zstep, zr, zsh;
  logic [CNT_W-1:0]     cnt_r;
  logic                 gon_r;
  logic signed [15:0]   gsel_r, held_r;
  logic                 out_valid_r, out_upd_r, out_rot_r;
  logic signed [15:0]   out_ang_r;

  logic                 pop, res_take, res_upd, cur_gon;
  logic signed [15:0]   res_ang, cur_gsel, cmp, fin_ang;

  assign {qd1, qd2, qupd, qgon, qgsel} = q_data;
  assign q_ready = (st_r == B_IDLE) && !out_valid_r;
  assign pop     = q_valid && q_ready;

  assign x0 = CW'(qd2) <<< PRE_SHIFT;
  assign y0 = CW'(qd1) <<< PRE_SHIFT;

  assign sx    = cx_r >>> cnt_r;
  assign sy    = cy_r >>> cnt_r;
  assign zstep = ZW'({1'b0, ATAN_TBL[TI_W'(cnt_r)]});

  assign zr  = z_r + ZHALF;
  assign zsh = zr >>> ANG_FRAC;
  always_comb begin
    if (zsh > ZMAX)       fin_ang = A_MAX;
    else if (zsh < -ZMAX) fin_ang = -A_MAX;
    else                  fin_ang = 16'(zsh);
  end

  // result selection: direct from the queue or at the end of the iterations
  always_comb begin
    res_take = 1'b0;
    res_upd  = 1'b0;
    res_ang  = held_r;
    cur_gon  = gon_r;
    cur_gsel = gsel_r;
    if (st_r == B_FIN) begin
      res_take = 1'b1;
      res_upd  = 1'b1;
      res_ang  = fin_ang;
    end else if (pop) begin
      cur_gon  = qgon;
      cur_gsel = qgsel;
      if (!qupd) begin
        res_take = 1'b1;
      end else if (qd1 == '0) begin
        res_take = 1'b1;
        res_upd  = 1'b1;
        res_ang  = qd2[DW-1] ? A_MAX : 16'sd0;
      end else if (qd2 == '0) begin
        res_take = 1'b1;
        res_upd  = 1'b1;
        res_ang  = qd1[DW-1] ? -A_90 : A_90;
      end
    end
  end

  assign cmp = cur_gon ? cur_gsel : res_ang;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      unique case (st_r)
        B_IDLE: begin
          if (pop && !res_take) begin
            st_r  <= B_ITER;
            cnt_r <= '0;
          end
        end
        B_ITER: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) st_r <= B_FIN;
        end
        B_FIN:   st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
      if (res_take) begin
        out_valid_r <= 1'b1;
        if (res_upd) held_r <= res_ang;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_ang_r <= res_ang;
      out_upd_r <= res_upd;
      out_rot_r <= (cmp >= cfg.rotation_threshold);
    end
    if (pop) begin
      gon_r  <= qgon;
      gsel_r <= qgsel;
      // quadrant pre-rotation by +-90 degrees
      if (qd2[DW-1]) begin
        if (!qd1[DW-1]) begin
          cx_r <= y0; cy_r <= -x0; z_r <= DEG90;
        end else begin
          cx_r <= -y0; cy_r <= x0; z_r <= -DEG90;
        end
      end else begin
        cx_r <= x0; cy_r <= y0; z_r <= '0;
      end
    end else if (st_r == B_ITER) begin
      if (!cy_r[CW-1]) begin
        cx_r <= cx_r + sy; cy_r <= cy_r - sx; z_r <= z_r + zstep;
      end else begin
        cx_r <= cx_r - sy; cy_r <= cy_r + sx; z_r <= z_r - zstep;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.tilt_angle    = out_ang_r;
  assign out_ch.angle_updated = out_upd_r;
  assign out_ch.rot_first     = out_rot_r;

  a_no_iter_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_ITER) |-> !out_valid_r)
    else $error("iterating while a result is pending");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ang_r <= A_MAX && out_ang_r >= -A_MAX))
    else $error("tilt angle out of range");

  a_hold_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (res_take && !res_upd) |=> (held_r == $past(held_r)))
    else $error("held angle changed without an update");

  a_fin_after_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_FIN) |-> ($past(st_r) == B_ITER))
    else $error("final step not preceded by iteration");

endmodule

`default_nettype wire

// File: tb/tb_accel_tilt_angle_detector_unit.sv
// ----------------------------------------------------------------------------
// Tilt angle detector testbench
// Drives accelerometer samples through the sample channel and predicts each
// tilt result: windowed means, limit test, CORDIC atan2 and rotation flag.
// Registers are changed over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_accel_tilt_angle_detector_unit;
  import atad_pkg::*;

  localparam int WIN   = 16;
  localparam int STEPS = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [15:0] tilt_angle;
    logic               angle_updated;
    logic               rot_first;
  } tilt_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  atad_in_if  in_ch ();
  atad_out_if out_ch ();

  accel_tilt_angle_detector_unit #(.WINDOW_LEN(WIN), .CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  cfg_t        cfg_m;
  logic signed [15:0] win1 [WIN];
  logic signed [15:0] win2 [WIN];
  longint      sum1, sum2;
  int          wr_idx;
  bit          is_primed;
  int          angle_hold;
  longint      atan_step [STEPS];

  tilt_res_t   expected_tilts[$];
  int          n_errors = 0;
  longint      cycles = 0;
  bit          long_hold = 1'b0;
  bit          stall_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_accel_tilt_angle_detector_unit failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    n_errors++;
  endtask

  function automatic longint q32_atan_inv(input longint unsigned n);
    longint unsigned p, n2, acc, k;
    p = (64'd1 << 32) / n;
    n2 = n * n;
    acc = 0;
    k = 0;
    while (p != 0) begin
      if (k[0] == 1'b0) acc += p / (2 * k + 1);
      else              acc -= p / (2 * k + 1);
      p /= n2;
      k++;
    end
    return acc;
  endfunction

  function automatic longint sra(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic int tilt_atan2(input longint y, input longint x);
    longint cx, cy, z, t, r, sx, sy;
    if (y == 0) return (x < 0) ? ANGLE_MAX : 0;
    if (x == 0) return (y > 0) ? ANGLE_MAX / 2 : -(ANGLE_MAX / 2);
    cx = x <<< PRE_SHIFT;
    cy = y <<< PRE_SHIFT;
    z = 0;
    if (cx < 0) begin
      t = cx;
      if (cy >= 0) begin
        cx = cy; cy = -t; z = longint'(90 * 128) <<< ANG_FRAC;
      end else begin
        cx = -cy; cy = t; z = -(longint'(90 * 128) <<< ANG_FRAC);
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = sra(cx, i);
      sy = sra(cy, i);
      if (cy >= 0) begin
        cx += sy; cy -= sx; z += atan_step[i];
      end else begin
        cx -= sy; cy += sx; z -= atan_step[i];
      end
    end
    r = sra(z + (longint'(1) <<< (ANG_FRAC - 1)), ANG_FRAC);
    if (r > ANGLE_MAX) r = ANGLE_MAX;
    if (r < -ANGLE_MAX) r = -ANGLE_MAX;
    return int'(r);
  endfunction

  task automatic reset_model();
    longint unsigned quarter;
    cfg_m = '{about_axis: AXIS_X, first_axis_offset: 16'sd0, second_axis_offset: 16'sd0,
              first_axis_limit: 16'hFFFF, second_axis_limit: 16'hFFFF,
              rotation_threshold: 16'sd0};
    sum1 = 0; sum2 = 0; wr_idx = 0; is_primed = 0; angle_hold = 0;
    quarter = q32_atan_inv(2) + q32_atan_inv(3);
    atan_step[0] = longint'(45) <<< 23;
    for (int i = 1; i < STEPS; i++)
      atan_step[i] = longint'(q32_atan_inv(64'd1 << i) * 45 * (64'd1 << 23) / quarter);
  endtask

  task automatic predict_tilt(input logic signed [15:0] ax, ay, az, input logic gyro_on,
                              input logic signed [15:0] gx, gy);
    longint a1, a2, d1, d2, m1, m2;
    int cmp;
    bit upd;
    tilt_res_t r;
    if (cfg_m.about_axis == AXIS_Y) begin a1 = ax; a2 = az; end
    else if (cfg_m.about_axis == AXIS_Z) begin a1 = ax; a2 = ay; end
    else begin a1 = ay; a2 = az; end
    if (!is_primed) begin
      for (int i = 0; i < WIN; i++) begin win1[i] = a1; win2[i] = a2; end
      sum1 = a1 * WIN; sum2 = a2 * WIN; wr_idx = 0; is_primed = 1;
    end
    sum1 += a1 - longint'(win1[wr_idx]);
    sum2 += a2 - longint'(win2[wr_idx]);
    win1[wr_idx] = a1;
    win2[wr_idx] = a2;
    wr_idx = (wr_idx + 1) % WIN;
    d1 = sum1 - longint'(cfg_m.first_axis_offset) * WIN;
    d2 = sum2 - longint'(cfg_m.second_axis_offset) * WIN;
    m1 = d1 < 0 ? -d1 : d1;
    m2 = d2 < 0 ? -d2 : d2;
    upd = (m1 <= longint'(cfg_m.first_axis_limit) * WIN) &&
          (m2 <= longint'(cfg_m.second_axis_limit) * WIN);
    if (upd) angle_hold = tilt_atan2(d1, d2);
    if (gyro_on) cmp = (cfg_m.about_axis == AXIS_Y || cfg_m.about_axis == AXIS_Z) ? gy : gx;
    else cmp = angle_hold;
    r.tilt_angle = angle_hold[15:0];
    r.angle_updated = upd;
    r.rot_first = (cmp >= int'(cfg_m.rotation_threshold));
    expected_tilts.push_back(r);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ABOUT_AXIS:  cfg_m.about_axis = val[1:0];
      REG_FIRST_OFFS:  cfg_m.first_axis_offset = val;
      REG_SECOND_OFFS: cfg_m.second_axis_offset = val;
      REG_FIRST_LIM:   cfg_m.first_axis_limit = val;
      REG_SECOND_LIM:  cfg_m.second_axis_limit = val;
      REG_THRESHOLD:   cfg_m.rotation_threshold = val;
      default: ;
    endcase
  endtask

  // burst/gap sender state
  int burst_left = 0;

  task automatic send_sample(input logic signed [15:0] ax, ay, az, input logic gyro_on,
                             input logic signed [15:0] gx, gy);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.accel_x = ax; in_ch.accel_y = ay; in_ch.accel_z = az;
    in_ch.gyro_enabled = gyro_on;
    in_ch.gyro_angle_x = gx; in_ch.gyro_angle_y = gy;
    do @(posedge clk); while (!in_ch.ready);
    predict_tilt(ax, ay, az, gyro_on, gx, gy);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_tilts.size() != 0) @(negedge clk);
    repeat (STEPS + 10) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_gyro();
    return 16'($signed($urandom_range(0, 46080)) - 23040);
  endfunction

  task automatic send_random(input int n, input int span);
    logic signed [15:0] bx, by, bz;
    bx = 16'($urandom); by = 16'($urandom); bz = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      // mostly small jitter around a base that is now and then redrawn, sometimes full range
      if ($urandom_range(0, 9) == 0)
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                    rand_gyro(), rand_gyro());
      else
        send_sample(16'(bx + $signed($urandom_range(0, 2 * span)) - span),
                    16'(by + $signed($urandom_range(0, 2 * span)) - span),
                    16'(bz + $signed($urandom_range(0, 2 * span)) - span),
                    1'($urandom), rand_gyro(), rand_gyro());
      if ($urandom_range(0, 40) == 0) begin
        bx = 16'($urandom); by = 16'($urandom); bz = 16'($urandom);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    tilt_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_tilts.size() == 0) begin
        report_mismatch("unexpected transaction", out_ch.tilt_angle, 0);
      end else begin
        e = expected_tilts.pop_front();
        if (out_ch.tilt_angle !== e.tilt_angle)
          report_mismatch("tilt_angle", out_ch.tilt_angle, e.tilt_angle);
        if (out_ch.angle_updated !== e.angle_updated)
          report_mismatch("angle_updated", out_ch.angle_updated, e.angle_updated);
        if (out_ch.rot_first !== e.rot_first)
          report_mismatch("rot_first", out_ch.rot_first, e.rot_first);
      end
    end
  end

  // receiver stall pattern, plus one long hold-off
  always @(negedge clk) begin
    if (long_hold) out_ch.ready <= 1'b0;
    else if (!stall_on) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic test_directed();
    logic signed [15:0] ext [4];
    ext = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    // prime with zeros: both means zero
    send_sample(0, 0, 0, 0, 0, 0);
    // extremes, all axes, both gyro settings
    for (int i = 0; i < 4; i++)
      send_sample(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], 1'(i), 16'sd23040, -16'sd23040);
    wait_idle();
    for (int a = 0; a < 4; a++) begin
      apb_write(REG_ABOUT_AXIS, 16'(a));
      send_sample(-16'sd1000, 16'sd0, 16'sd500, 1, -16'sd23040, 16'sd23040);
      send_sample(16'sd0, -16'sd2000, 16'sd0, 0, 16'sd0, 16'sd0);
      wait_idle();
    end
  endtask

  task automatic test_limits_offsets();
    apb_write(REG_ABOUT_AXIS, AXIS_X);
    apb_write(REG_FIRST_OFFS, 16'h8000);
    apb_write(REG_SECOND_OFFS, 16'h7FFF);
    apb_write(REG_FIRST_LIM, 16'd0);
    apb_write(REG_SECOND_LIM, 16'd100);
    apb_write(REG_THRESHOLD, 16'(-23040));
    send_random(40, 300);
    wait_idle();
    apb_write(REG_FIRST_OFFS, 16'd0);
    apb_write(REG_SECOND_OFFS, 16'd0);
    apb_write(REG_FIRST_LIM, 16'd200);
    apb_write(REG_THRESHOLD, 16'd23040);
    send_random(40, 300);
    wait_idle();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      apb_write(REG_ABOUT_AXIS, 16'($urandom_range(0, 3)));
      apb_write(REG_FIRST_OFFS, ph < 5 ? 16'd0 : 16'($urandom_range(0, 4000) - 2000));
      apb_write(REG_SECOND_OFFS, ph < 5 ? 16'd0 : 16'($urandom_range(0, 4000) - 2000));
      apb_write(REG_FIRST_LIM, ph % 2 ? 16'hFFFF : 16'($urandom_range(2000, 40000)));
      apb_write(REG_SECOND_LIM, ph % 3 ? 16'hFFFF : 16'($urandom_range(2000, 40000)));
      apb_write(REG_THRESHOLD, 16'($urandom_range(0, 46080) - 23040));
      stall_on = (ph % 4 != 3);
      send_random(100, ph % 2 ? 20000 : 500);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      send_random(30, 1000);
    join
    wait_idle();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
    in_ch.gyro_enabled = 1'b0; in_ch.gyro_angle_x = '0; in_ch.gyro_angle_y = '0;
    out_ch.ready = 1'b0;
    reset_model();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    test_directed();
    test_limits_offsets();
    test_backpressure();
    test_random();
    wait_idle();
    if (n_errors == 0 && expected_tilts.size() == 0)
      $display("tb_accel_tilt_angle_detector_unit passed");
    else
      $display("tb_accel_tilt_angle_detector_unit failed");
    $finish;
  end

endmodule

`default_nettype wire
